// ===== rtl/mvd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_pkg
// Shared widths, reset values and lane control type for the magnetic
// vehicle detector.
// ----------------------------------------------------------------------------
package mvd_pkg;

    localparam int SAMPLE_W       = 16;
    localparam int SUM_OUT_W      = 21;
    localparam int THRESH_W       = 16;
    localparam int THRESH_RESET   = 90;
    localparam int WINDOW_DEFAULT = 20;
    localparam int FIFO_DEPTH     = 4;

    typedef struct packed {
        logic load;        // sample word accepted this cycle
        logic s1_valid;    // stage 1 holds a word
        logic s1_capture;  // stage 1 word is the baseline capture word
    } lane_ctrl_t;

endpackage : mvd_pkg
`default_nettype wire

// ===== rtl/mvd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_if
// Valid/ready channels of the magnetic vehicle detector: sample input,
// result output and threshold write.
// ----------------------------------------------------------------------------
interface mvd_in_if;
    import mvd_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] z_sample;

    modport source (output valid, output x_sample, output z_sample, input ready);
    modport sink   (input valid, input x_sample, input z_sample, output ready);
endinterface : mvd_in_if

interface mvd_out_if;
    import mvd_pkg::*;
    logic                        valid;
    logic                        ready;
    logic signed [SUM_OUT_W-1:0] x_window_sum;
    logic                        vehicle_present;

    modport source (output valid, output x_window_sum, output vehicle_present,
                    input ready);
    modport sink   (input valid, input x_window_sum, input vehicle_present,
                    output ready);
endinterface : mvd_out_if

interface mvd_cfg_if;
    import mvd_pkg::*;
    logic                valid;
    logic                ready;
    logic [THRESH_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : mvd_cfg_if
`default_nettype wire

// ===== rtl/mvd_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_lane
// One axis: sample ring, running window sum, baseline capture and the
// deviation compare against the scaled threshold. Two register stages.
// ----------------------------------------------------------------------------
module mvd_lane
    import mvd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire lane_ctrl_t                               ctrl,
    input  wire logic [$clog2(WINDOW)-1:0]                slot,
    input  wire logic signed [SAMPLE_W-1:0]               sample,
    input  wire logic [SAMPLE_W+$clog2(WINDOW)-1:0]       limit,
    output logic signed [SAMPLE_W+$clog2(WINDOW)-1:0]     sum,
    output logic                                          hit
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    localparam int SW2   = SUM_W + 2;

    logic signed [SAMPLE_W-1:0] ring_reg [WINDOW];
    logic signed [SUM_W-1:0]    sum_reg;
    logic signed [SUM_W-1:0]    sum_next;
    logic [SUM_W-1:0]           base_reg;
    logic signed [SUM_W-1:0]    out_sum_reg;
    logic                       hit_reg;
    logic                       hit_next;

    logic signed [SW2-1:0] s_ext;
    logic signed [SW2-1:0] mag;
    logic signed [SW2-1:0] base_eff;
    logic signed [SW2-1:0] diff;
    logic signed [SW2-1:0] dev;
    logic signed [SW2-1:0] limit_ext;

    assign sum_next = sum_reg + SUM_W'(sample) - SUM_W'(ring_reg[slot]);

    always_comb
    begin
        s_ext     = SW2'(sum_reg);
        mag       = (s_ext < 0) ? -s_ext : s_ext;
        base_eff  = ctrl.s1_capture ? mag : SW2'(base_reg);
        diff      = s_ext - base_eff;
        dev       = (diff < 0) ? -diff : diff;
        limit_ext = SW2'(limit);
        hit_next  = (dev >= limit_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW; i++)
            begin
                ring_reg[i] <= '0;
            end
            sum_reg  <= '0;
            base_reg <= '0;
        end
        else
        begin
            if (ctrl.load)
            begin
                ring_reg[slot] <= sample;
                sum_reg        <= sum_next;
            end
            if (ctrl.s1_capture)
            begin
                base_reg <= mag[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_valid)
        begin
            out_sum_reg <= sum_reg;
            hit_reg     <= hit_next;
        end
    end

    assign sum = out_sum_reg;
    assign hit = hit_reg;

endmodule : mvd_lane
`default_nettype wire

// ===== rtl/mvd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mvd_merge
// Combines the lane flags, trims the X sum to the output width and queues
// result words in a small output FIFO.
// ----------------------------------------------------------------------------
module mvd_merge
    import mvd_pkg::*;
#(
    parameter int SUM_W = SAMPLE_W + $clog2(WINDOW_DEFAULT)
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic signed [SUM_W-1:0]       x_sum,
    input  wire logic                          x_hit,
    input  wire logic                          z_hit,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]    fill,
    mvd_out_if.source                          results
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int EXT_W = (SUM_W > SUM_OUT_W) ? SUM_W : SUM_OUT_W;

    logic signed [SUM_OUT_W-1:0] sum_q [FIFO_DEPTH];
    logic                        flag_q [FIFO_DEPTH];
    logic [PTR_W-1:0]            wr_ptr_reg;
    logic [PTR_W-1:0]            rd_ptr_reg;
    logic [CNT_W-1:0]            count_reg;
    logic signed [EXT_W-1:0]     sum_ext;
    logic                        pop;

    assign sum_ext = EXT_W'(x_sum);
    assign pop     = results.valid && results.ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            sum_q[wr_ptr_reg]  <= sum_ext[SUM_OUT_W-1:0];
            flag_q[wr_ptr_reg] <= x_hit || z_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign results.valid           = (count_reg != '0);
    assign results.x_window_sum    = sum_q[rd_ptr_reg];
    assign results.vehicle_present = flag_q[rd_ptr_reg];
    assign fill                    = count_reg;

endmodule : mvd_merge
`default_nettype wire

// ===== rtl/magnetic_vehicle_detector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// magnetic_vehicle_detector
// Moving-average baseline detector on X and Z magnetometer samples.
// ----------------------------------------------------------------------------
// Takes one sample word per cycle, back to back, while input ready is high.
// Each word goes through two register stages (running-sum update, then
// baseline/deviation compare in the X and Z lanes) and a four-entry output
// FIFO before its result word appears. The first WINDOW words only fill
// the rings and give no result; word WINDOW+1 captures both baselines and it
// and every later word give one result. Input ready drops only when the words
// in flight plus those queued reach the FIFO depth. Threshold writes are taken
// at any time (ready is always high) and are meant to be made while idle.
// ----------------------------------------------------------------------------
module magnetic_vehicle_detector
    import mvd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mvd_in_if.sink     samples,
    mvd_cfg_if.sink    threshold,
    mvd_out_if.source  results
);

    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int WARM_W = $clog2(WINDOW + 2);
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);

    logic [SLOT_W-1:0]       slot_reg;
    logic [WARM_W-1:0]       warm_reg;
    logic [SUM_W-1:0]        limit_reg;
    logic                    s1_valid_reg;
    logic                    s1_result_reg;
    logic                    s1_capture_reg;
    logic                    s2_valid_reg;
    logic                    s2_result_reg;
    logic                    load;
    logic                    warm_done;
    logic                    at_window;
    logic [CNT_W-1:0]        fill;
    logic [CNT_W-1:0]        occupancy;
    lane_ctrl_t              lane_ctrl;
    logic signed [SUM_W-1:0] x_sum;
    logic signed [SUM_W-1:0] z_sum;
    logic                    x_hit;
    logic                    z_hit;

    assign occupancy       = CNT_W'(s1_valid_reg) + CNT_W'(s2_valid_reg) + fill;
    assign samples.ready   = (occupancy < CNT_W'(FIFO_DEPTH));
    assign threshold.ready = 1'b1;
    assign load            = samples.valid && samples.ready;
    assign warm_done       = (warm_reg == WARM_W'(WINDOW + 1));
    assign at_window       = (warm_reg == WARM_W'(WINDOW));

    assign lane_ctrl = '{load: load, s1_valid: s1_valid_reg, s1_capture: s1_capture_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg       <= '0;
            warm_reg       <= '0;
            limit_reg      <= SUM_W'(THRESH_RESET * WINDOW);
            s1_valid_reg   <= 1'b0;
            s1_result_reg  <= 1'b0;
            s1_capture_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            s2_result_reg  <= 1'b0;
        end
        else
        begin
            if (threshold.valid)
            begin
                limit_reg <= SUM_W'(32'(threshold.data) * WINDOW);
            end
            if (load)
            begin
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                if (!warm_done)
                begin
                    warm_reg <= warm_reg + 1'b1;
                end
            end
            s1_valid_reg   <= load;
            s1_result_reg  <= load && (warm_done || at_window);
            s1_capture_reg <= load && at_window;
            s2_valid_reg   <= s1_valid_reg;
            s2_result_reg  <= s1_result_reg;
        end
    end

    mvd_lane #(.WINDOW(WINDOW)) u_x_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .slot   (slot_reg),
        .sample (samples.x_sample),
        .limit  (limit_reg),
        .sum    (x_sum),
        .hit    (x_hit)
    );

    mvd_lane #(.WINDOW(WINDOW)) u_z_lane (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (lane_ctrl),
        .slot   (slot_reg),
        .sample (samples.z_sample),
        .limit  (limit_reg),
        .sum    (z_sum),
        .hit    (z_hit)
    );

    mvd_merge #(.SUM_W(SUM_W)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (s2_result_reg),
        .x_sum   (x_sum),
        .x_hit   (x_hit),
        .z_hit   (z_hit),
        .fill    (fill),
        .results (results)
    );

    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= CNT_W'(FIFO_DEPTH))
        else $error("pipeline plus FIFO overfilled");

    a_result_after_warmup: assert property (@(posedge clk) disable iff (!rst_n)
        s2_result_reg |-> warm_done)
        else $error("result word before warmup done");

    a_single_capture: assert property (@(posedge clk) disable iff (!rst_n)
        s1_capture_reg |=> !s1_capture_reg && !at_window)
        else $error("baseline captured twice");

    a_capture_is_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_capture_reg |-> s1_result_reg && s1_valid_reg)
        else $error("capture word without result");

    a_z_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (z_sum >= -(WINDOW * (2 ** (SAMPLE_W - 1)))) &&
                         (z_sum <= WINDOW * (2 ** (SAMPLE_W - 1) - 1)))
        else $error("Z window sum out of range");

endmodule : magnetic_vehicle_detector
`default_nettype wire
